@@ rtl/r2ep_pkg.sv @@
package r2ep_pkg;

   localparam int PANEL_WIDTH_DEFAULT  = 1440;
   localparam int PANEL_HEIGHT_DEFAULT = 720;

   localparam int ADDR_W = 19;
   localparam int COL_W  = 11;
   localparam int ROW_W  = 10;

   localparam logic [7:0] GRAY_R_WEIGHT = 8'd76;
   localparam logic [7:0] GRAY_G_WEIGHT = 8'd150;
   localparam logic [7:0] GRAY_B_WEIGHT = 8'd30;
   localparam logic [7:0] FIXED_THRESHOLD = 8'd128;
   localparam logic [7:0] MASK_1BPP_MSB = 8'h80;
   localparam logic [7:0] MASK_LO_NIBBLE = 8'h0F;
   localparam logic [7:0] MASK_HI_NIBBLE = 8'hF0;

   localparam logic [COL_W-1:0] AREA_X1_RESET = 11'd0;
   localparam logic [ROW_W-1:0] AREA_Y1_RESET = 10'd0;
   localparam logic [COL_W-1:0] AREA_X2_RESET = 11'd1439;
   localparam logic [ROW_W-1:0] AREA_Y2_RESET = 10'd719;
   localparam logic [1:0]       MIRROR_RESET  = 2'd1;

   typedef enum logic [2:0] {
      CSR_AREA_X1     = 3'd0,
      CSR_AREA_Y1     = 3'd1,
      CSR_AREA_X2     = 3'd2,
      CSR_AREA_Y2     = 3'd3,
      CSR_MIRROR_MODE = 3'd4,
      CSR_GRAY_4BPP   = 3'd5,
      CSR_DITHER_ON   = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [4:0]       red;
      logic [5:0]       green;
      logic [4:0]       blue;
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
   } req_payload_type;

   typedef struct packed {
      logic              write_enable;
      logic [ADDR_W-1:0] byte_address;
      logic [7:0]        write_data;
      logic [7:0]        byte_mask;
      logic [7:0]        gray_level;
   } rsp_payload_type;

   localparam logic [3:0] BAYER_TAB [4][4] = '{
      '{4'd0,  4'd8,  4'd2,  4'd10},
      '{4'd12, 4'd4,  4'd14, 4'd6},
      '{4'd3,  4'd11, 4'd1,  4'd9},
      '{4'd15, 4'd7,  4'd13, 4'd5}
   };

   // Bayer entry scaled by 16
   function automatic logic [7:0] bayer_threshold(input logic [1:0] y, input logic [1:0] x);
      return {BAYER_TAB[y][x], 4'b0000};
   endfunction

endpackage

@@ rtl/rgb565_to_epaper_pixel_packer_unit.sv @@
// RGB565 to e-paper framebuffer pixel packer.
//
// Request channel (req_valid / req_stall / req_payload): one RGB565 pixel plus
// its column and row offset inside the flushed area per beat. A beat is taken
// at a clock edge where req_valid is high and req_stall is low.
// Response channel (rsp_valid / rsp_stall / rsp_payload): one masked byte
// write per pixel for an external framebuffer, which merges the masked bits.
// Register port (csr_valid / csr_ready / csr_index / csr_data): always ready;
// write the area, mirror and format registers only while the pipe is empty.
//
// A request beat passes four register stages to its response beat: weight
// products, gray sum and panel position, row base multiply and bit select,
// address add into the output register.
// Throughput is one pixel per clock while the receiver does not stall.
// Synchronous reset empties the pipe and loads the register defaults.
// When the receiver stalls, the output register holds its beat; upstream
// stages keep filling bubbles and req_stall rises once every stage is full.
module rgb565_to_epaper_pixel_packer_unit #(
   parameter int PANEL_WIDTH  = r2ep_pkg::PANEL_WIDTH_DEFAULT,
   parameter int PANEL_HEIGHT = r2ep_pkg::PANEL_HEIGHT_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  r2ep_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output r2ep_pkg::rsp_payload_type rsp_payload,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  r2ep_pkg::csr_index_type   csr_index,
   input  logic [10:0]               csr_data
);
   import r2ep_pkg::*;

   localparam int PITCH_4BPP = (PANEL_WIDTH + 1) / 2;
   localparam int PITCH_1BPP = (PANEL_WIDTH + 7) / 8;
   localparam int PITCH_W    = $clog2(PITCH_4BPP + 1);
   localparam int PROD_W     = ROW_W + PITCH_W;

   // ---------------- configuration registers ----------------
   logic [COL_W-1:0] area_x1_ff, area_x2_ff;
   logic [ROW_W-1:0] area_y1_ff, area_y2_ff;
   logic [1:0]       mirror_ff;
   logic             gray_4bpp_ff, dither_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         area_x1_ff   <= AREA_X1_RESET;
         area_y1_ff   <= AREA_Y1_RESET;
         area_x2_ff   <= AREA_X2_RESET;
         area_y2_ff   <= AREA_Y2_RESET;
         mirror_ff    <= MIRROR_RESET;
         gray_4bpp_ff <= 1'b0;
         dither_ff    <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_AREA_X1:     area_x1_ff   <= csr_data;
            CSR_AREA_Y1:     area_y1_ff   <= csr_data[ROW_W-1:0];
            CSR_AREA_X2:     area_x2_ff   <= csr_data;
            CSR_AREA_Y2:     area_y2_ff   <= csr_data[ROW_W-1:0];
            CSR_MIRROR_MODE: mirror_ff    <= csr_data[1:0];
            CSR_GRAY_4BPP:   gray_4bpp_ff <= csr_data[0];
            CSR_DITHER_ON:   dither_ff    <= csr_data[0];
            default: ; // drop writes beyond the register list
         endcase
      end
   end

   // ---------------- stage enables ----------------
   // Each stage advances when it is empty or the next stage advances.
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, out_valid_ff;
   logic s1_en, s2_en, s3_en, out_en;

   assign out_en    = !out_valid_ff || !rsp_stall;
   assign s3_en     = !s3_valid_ff || out_en;
   assign s2_en     = !s2_valid_ff || s3_en;
   assign s1_en     = !s1_valid_ff || s2_en;
   assign req_stall = !s1_en;
   assign rsp_valid = out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (s1_en)  s1_valid_ff  <= req_valid;
         if (s2_en)  s2_valid_ff  <= s1_valid_ff;
         if (s3_en)  s3_valid_ff  <= s2_valid_ff;
         if (out_en) out_valid_ff <= s3_valid_ff;
      end
   end

   // ---------------- stage 1: weight products, area test, mirror ----------------
   logic [15:0]      s1_prod_r_in, s1_prod_g_in, s1_prod_b_in;
   logic [15:0]      s1_prod_r_ff, s1_prod_g_ff, s1_prod_b_ff;
   logic             s1_inside_in, s1_inside_ff;
   logic [COL_W-1:0] s1_ox_in, s1_ox_ff;
   logic [ROW_W-1:0] s1_oy_in, s1_oy_ff;

   logic [7:0]        r8, g8, b8;
   logic signed [12:0] area_w, col_s, ox_mirror;
   logic signed [11:0] area_h, row_s, oy_mirror;

   always_comb begin
      // widen by replicating the top bits
      r8 = {req_payload.red,   req_payload.red[4:2]};
      g8 = {req_payload.green, req_payload.green[5:4]};
      b8 = {req_payload.blue,  req_payload.blue[4:2]};
      s1_prod_r_in = 16'(r8) * 16'(GRAY_R_WEIGHT);
      s1_prod_g_in = 16'(g8) * 16'(GRAY_G_WEIGHT);
      s1_prod_b_in = 16'(b8) * 16'(GRAY_B_WEIGHT);

      // area size goes negative or zero for an empty area
      area_w = $signed({2'b00, area_x2_ff}) - $signed({2'b00, area_x1_ff}) + 13'sd1;
      area_h = $signed({2'b00, area_y2_ff}) - $signed({2'b00, area_y1_ff}) + 12'sd1;
      col_s  = $signed({2'b00, req_payload.col});
      row_s  = $signed({2'b00, req_payload.row});
      s1_inside_in = (col_s < area_w) && (row_s < area_h);

      ox_mirror = area_w - 13'sd1 - col_s;
      oy_mirror = area_h - 12'sd1 - row_s;
      s1_ox_in  = mirror_ff[0] ? ox_mirror[COL_W-1:0] : req_payload.col;
      s1_oy_in  = mirror_ff[1] ? oy_mirror[ROW_W-1:0] : req_payload.row;
   end

   always_ff @(posedge clock) begin
      if (s1_en) begin
         s1_prod_r_ff <= s1_prod_r_in;
         s1_prod_g_ff <= s1_prod_g_in;
         s1_prod_b_ff <= s1_prod_b_in;
         s1_inside_ff <= s1_inside_in;
         s1_ox_ff     <= s1_ox_in;
         s1_oy_ff     <= s1_oy_in;
      end
   end

   // ---------------- stage 2: gray sum, panel position ----------------
   logic [7:0]       s2_gray_in, s2_gray_ff;
   logic             s2_we_in, s2_we_ff;
   logic [COL_W-1:0] s2_dx_in, s2_dx_ff;
   logic [ROW_W-1:0] s2_dy_in, s2_dy_ff;

   logic [15:0]      gray_sum;
   logic [COL_W:0]   dx_full;
   logic [ROW_W:0]   dy_full;

   always_comb begin
      gray_sum   = s1_prod_r_ff + s1_prod_g_ff + s1_prod_b_ff;
      s2_gray_in = gray_sum[15:8];
      dx_full    = {1'b0, area_x1_ff} + {1'b0, s1_ox_ff};
      dy_full    = {1'b0, area_y1_ff} + {1'b0, s1_oy_ff};
      s2_we_in   = s1_inside_ff && (32'(dx_full) < PANEL_WIDTH)
                                && (32'(dy_full) < PANEL_HEIGHT);
      s2_dx_in   = dx_full[COL_W-1:0];
      s2_dy_in   = dy_full[ROW_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (s2_en) begin
         s2_gray_ff <= s2_gray_in;
         s2_we_ff   <= s2_we_in;
         s2_dx_ff   <= s2_dx_in;
         s2_dy_ff   <= s2_dy_in;
      end
   end

   // ---------------- stage 3: row base, bit select ----------------
   logic [7:0]        s3_gray_ff;
   logic              s3_we_ff;
   logic [ADDR_W-1:0] s3_row_base_in, s3_row_base_ff;
   logic [COL_W-2:0]  s3_col_byte_in, s3_col_byte_ff;
   logic [7:0]        s3_data_in, s3_data_ff;
   logic [7:0]        s3_mask_in, s3_mask_ff;

   logic [PITCH_W-1:0] pitch;
   logic [PROD_W-1:0]  row_prod;
   logic [7:0]         thr, mask_1bpp;
   logic [3:0]         g4;

   always_comb begin
      pitch          = gray_4bpp_ff ? PITCH_W'(PITCH_4BPP) : PITCH_W'(PITCH_1BPP);
      row_prod       = PROD_W'(s2_dy_ff) * PROD_W'(pitch);
      s3_row_base_in = ADDR_W'(row_prod);
      s3_col_byte_in = gray_4bpp_ff ? s2_dx_ff[COL_W-1:1]
                                    : (COL_W-1)'(s2_dx_ff[COL_W-1:3]);
      g4        = s2_gray_ff[7:4];
      thr       = dither_ff ? bayer_threshold(s2_dy_ff[1:0], s2_dx_ff[1:0])
                            : FIXED_THRESHOLD;
      mask_1bpp = MASK_1BPP_MSB >> s2_dx_ff[2:0];
      if (!s2_we_ff) begin
         s3_data_in = 8'h00;
         s3_mask_in = 8'h00;
      end else if (gray_4bpp_ff) begin
         // even column fills the high nibble
         s3_data_in = s2_dx_ff[0] ? {4'h0, g4} : {g4, 4'h0};
         s3_mask_in = s2_dx_ff[0] ? MASK_LO_NIBBLE : MASK_HI_NIBBLE;
      end else begin
         s3_data_in = (s2_gray_ff >= thr) ? mask_1bpp : 8'h00;
         s3_mask_in = mask_1bpp;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_en) begin
         s3_gray_ff     <= s2_gray_ff;
         s3_we_ff       <= s2_we_ff;
         s3_row_base_ff <= s3_row_base_in;
         s3_col_byte_ff <= s3_col_byte_in;
         s3_data_ff     <= s3_data_in;
         s3_mask_ff     <= s3_mask_in;
      end
   end

   // ---------------- output register ----------------
   rsp_payload_type out_in, out_ff;

   always_comb begin
      out_in.write_enable = s3_we_ff;
      out_in.byte_address = s3_we_ff ? (s3_row_base_ff + ADDR_W'(s3_col_byte_ff))
                                     : '0;
      out_in.write_data   = s3_data_ff;
      out_in.byte_mask    = s3_mask_ff;
      out_in.gray_level   = s3_gray_ff;
   end

   // hold the beat while the receiver stalls
   always_ff @(posedge clock) begin
      if (out_en) out_ff <= out_in;
   end

   assign rsp_payload = out_ff;

endmodule

@@ rtl/r2ep_checker.sv @@
module r2ep_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input r2ep_pkg::rsp_payload_type rsp_payload
);
   import r2ep_pkg::*;

   // a stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("response beat changed under stall");

   // pipe empties on reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // guarded pixels carry no write
   a_guard_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.write_enable |->
         rsp_payload.byte_address == '0 && rsp_payload.write_data == 8'h00 &&
         rsp_payload.byte_mask == 8'h00)
      else $error("guarded pixel has write fields");

   // mask is one bit or one nibble, data inside it
   a_mask_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.write_enable |->
         ($countones(rsp_payload.byte_mask) == 1 ||
          rsp_payload.byte_mask == MASK_HI_NIBBLE ||
          rsp_payload.byte_mask == MASK_LO_NIBBLE) &&
         ((rsp_payload.write_data & ~rsp_payload.byte_mask) == 8'h00))
      else $error("bad byte mask or data outside mask");

endmodule

bind rgb565_to_epaper_pixel_packer_unit r2ep_checker u_r2ep_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);
